// ===== sv/pps_pkg.sv =====
// Package for the pure pursuit steering block: payload structs, widths,
// mode and register codes, CORDIC arctangent table. No dependencies.
`default_nettype none
package pps_pkg;

    localparam int PATH_DEPTH_DEF = 1024;
    localparam int COORD_W        = 24;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int SQ_W           = 2 * DIFF_W;
    localparam int ROOT_W         = DIFF_W;
    localparam int LOOK_W         = 23;
    localparam int ANGLE_W        = 16;
    localparam int HEAD_W         = 16;
    localparam int CMD_W          = 16;
    localparam int INDEX_OUT_W    = 10;
    localparam int LAT_W          = 28;
    localparam int CORDIC_STEPS   = 14;
    localparam int CORDIC_W       = 36;
    localparam int ZW             = 18;
    localparam int GAIN_W         = 31;
    localparam logic [GAIN_W-1:0] GAIN_INV = 31'd652032874;
    localparam logic [14:0] CMD_ONE = 15'd16384;
    localparam int CFG_W          = 23;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_POSE   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic CFG_LOOKAHEAD = 1'b0;
    localparam logic CFG_MAX_ANGLE = 1'b1;

    localparam logic [LOOK_W-1:0]  LOOK_RESET  = 23'd32768;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 16'd4096;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [HEAD_W-1:0]   heading;
    } in_item_t;

    typedef struct packed {
        logic signed [CMD_W-1:0]     steering_command;
        logic [INDEX_OUT_W-1:0]      closest_index;
        logic [INDEX_OUT_W-1:0]      lookahead_index;
    } out_item_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pps_point_mem.sv =====
// Path point store: one synchronous memory of x/y pairs, one write port,
// one read port with registered data. Depends on pps_pkg.
`default_nettype none
module pps_point_mem #(
    parameter int DEPTH = pps_pkg::PATH_DEPTH_DEF
) (
    input  wire                                     aclk,
    input  wire                                     wr_en,
    input  wire [$clog2(DEPTH)-1:0]                 wr_addr,
    input  wire signed [pps_pkg::COORD_W-1:0]       wr_x,
    input  wire signed [pps_pkg::COORD_W-1:0]       wr_y,
    input  wire                                     rd_en,
    input  wire [$clog2(DEPTH)-1:0]                 rd_addr,
    output logic signed [pps_pkg::COORD_W-1:0]      rd_x,
    output logic signed [pps_pkg::COORD_W-1:0]      rd_y
);
    import pps_pkg::*;

    logic [2*COORD_W-1:0] mem [DEPTH];
    logic [2*COORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_x = $signed(rdata_reg[2*COORD_W-1:COORD_W]);
    assign rd_y = $signed(rdata_reg[COORD_W-1:0]);

endmodule
`default_nettype wire

// ===== sv/pps_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on pps_pkg.
`default_nettype none
module pps_isqrt (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         start,
    input  wire [pps_pkg::SQ_W-1:0]     radicand,
    output logic                        done,
    output logic [pps_pkg::ROOT_W-1:0]  root
);
    import pps_pkg::*;

    logic [SQ_W-1:0] v_reg, r_reg, bit_reg;
    logic            busy_reg, done_reg;
    logic [SQ_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg    <= radicand;
                r_reg    <= '0;
                bit_reg  <= SQ_W'(1) << (SQ_W - 2);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (v_reg >= trial) begin
                    v_reg <= v_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== sv/pps_rotate.sv =====
// CORDIC rotation of the target offset into the car frame, one iteration
// per cycle, then gain compensation and rounding. Depends on pps_pkg.
`default_nettype none
module pps_rotate (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  start,
    input  wire signed [pps_pkg::DIFF_W-1:0]     dx,
    input  wire signed [pps_pkg::DIFF_W-1:0]     dy,
    input  wire signed [pps_pkg::HEAD_W-1:0]     head,
    output logic                                 done,
    output logic signed [pps_pkg::LAT_W-1:0]     lat
);
    import pps_pkg::*;

    typedef enum logic [1:0] {R_IDLE, R_ITER, R_MUL, R_ROUND} rstate_t;

    localparam int PROD_W = CORDIC_W - 8 + GAIN_W;

    rstate_t                    state_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [ZW-1:0]       z_reg;
    logic [3:0]                 step_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [LAT_W-1:0]    lat_reg;
    logic                       done_reg;

    logic signed [CORDIC_W-1:0] x0, y0, xs, ys;
    logic signed [ZW-1:0]       z0;
    logic signed [CORDIC_W-9:0] ysh;
    logic signed [PROD_W-1:0]   rounded;

    assign x0 = $signed({{(CORDIC_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'b0});
    assign y0 = $signed({{(CORDIC_W-DIFF_W-8){dy[DIFF_W-1]}}, dy, 8'b0});
    assign z0 = -$signed({{(ZW-HEAD_W){head[HEAD_W-1]}}, head});
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign ysh = y_reg[CORDIC_W-1:8];
    assign rounded = prod_reg + (PROD_W'(1) <<< 29);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        step_reg <= '0;
                        if (z0 > 18'sd16384) begin
                            x_reg <= -x0;
                            y_reg <= -y0;
                            z_reg <= z0 - 18'sd32768;
                        end else if (z0 < -18'sd16384) begin
                            x_reg <= -x0;
                            y_reg <= -y0;
                            z_reg <= z0 + 18'sd32768;
                        end else begin
                            x_reg <= x0;
                            y_reg <= y0;
                            z_reg <= z0;
                        end
                        state_reg <= R_ITER;
                    end
                end
                R_ITER: begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_entry(step_reg);
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_entry(step_reg);
                    end
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(CORDIC_STEPS - 1)) begin
                        state_reg <= R_MUL;
                    end
                end
                R_MUL: begin
                    prod_reg  <= PROD_W'(ysh * $signed({1'b0, GAIN_INV}));
                    state_reg <= R_ROUND;
                end
                R_ROUND: begin
                    lat_reg   <= rounded[LAT_W+29:30];
                    done_reg  <= 1'b1;
                    state_reg <= R_IDLE;
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign lat  = lat_reg;

endmodule
`default_nettype wire

// ===== sv/pps_cmd_div.sv =====
// Steering command: L^2*M in partial products, then restoring division
// with saturation to plus or minus one. Depends on pps_pkg.
`default_nettype none
module pps_cmd_div (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  start,
    input  wire signed [pps_pkg::LAT_W-1:0]      d,
    input  wire [pps_pkg::LOOK_W-1:0]            look,
    input  wire [pps_pkg::ANGLE_W-1:0]           angle,
    output logic                                 done,
    output logic signed [pps_pkg::CMD_W-1:0]     cmd
);
    import pps_pkg::*;

    typedef enum logic [2:0] {D_IDLE, D_SQ, D_LO, D_HI, D_CHK, D_ITER, D_FIN} dstate_t;

    localparam int R_W = 64;
    localparam int LSQ_W = 2 * LOOK_W;
    localparam int PP_W = LOOK_W + ANGLE_W;

    dstate_t               state_reg;
    logic                  neg_reg, zero_reg, done_reg;
    logic [LAT_W-1:0]      mag_reg;
    logic [LSQ_W-1:0]      lsq_reg;
    logic [R_W-1:0]        den_reg, r_reg;
    logic [14:0]           q_reg;
    logic [3:0]            step_reg;
    logic signed [CMD_W-1:0] cmd_reg;
    logic [R_W-1:0]        r_sh;
    logic [PP_W-1:0]       pp;

    assign r_sh = r_reg << 1;
    assign pp = (state_reg == D_LO) ? lsq_reg[LOOK_W-1:0] * angle
                                    : lsq_reg[LSQ_W-1:LOOK_W] * angle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        neg_reg   <= d[LAT_W-1];
                        zero_reg  <= (d == '0);
                        mag_reg   <= d[LAT_W-1] ? LAT_W'(-d) : LAT_W'(d);
                        state_reg <= D_SQ;
                    end
                end
                D_SQ: begin
                    lsq_reg   <= LSQ_W'(look * look);
                    state_reg <= D_LO;
                end
                D_LO: begin
                    den_reg   <= R_W'(pp);
                    r_reg     <= R_W'(mag_reg) << 29;
                    state_reg <= D_HI;
                end
                D_HI: begin
                    den_reg   <= den_reg + (R_W'(pp) << LOOK_W);
                    state_reg <= D_CHK;
                end
                D_CHK: begin
                    q_reg    <= '0;
                    step_reg <= '0;
                    if (zero_reg) begin
                        state_reg <= D_FIN;
                    end else if (r_reg >= den_reg) begin
                        q_reg     <= CMD_ONE;
                        state_reg <= D_FIN;
                    end else begin
                        state_reg <= D_ITER;
                    end
                end
                D_ITER: begin
                    if (r_sh >= den_reg) begin
                        r_reg <= r_sh - den_reg;
                        q_reg <= {q_reg[13:0], 1'b1};
                    end else begin
                        r_reg <= r_sh;
                        q_reg <= {q_reg[13:0], 1'b0};
                    end
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd13) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    cmd_reg   <= neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign cmd  = cmd_reg;

endmodule
`default_nettype wire

// ===== sv/pure_pursuit_steering.sv =====
// Pure pursuit steering top level: sequencer over the point store, nearest
// and lookahead searches. Depends on pps_pkg, pps_point_mem, pps_isqrt,
// pps_rotate and pps_cmd_div.
//
// Use: items arrive on s_item (valid/ready); mode selects append of a path
// point, a car pose update or a control tick. Append and pose items are
// handled in the idle state and give no result. A tick on a non-empty store
// gives one result on m_item (valid/ready): steering command and the nearest
// and target indices. Ticks on an empty store and mode three are taken and
// dropped. A tick runs the nearest search over all stored points, then the
// lookahead search with one bit-serial square root per point, then CORDIC
// and division. The single read port of the point store and the square
// root unit serve every point in turn.
// The block takes one item at a time; s_ready is low during a tick.
// A finished result waits in the output register while m_ready is low;
// the block then holds before loading the next result.
// Reset empties the store, zeroes the pose and loads L = 0.5 m and
// M = 1.0 rad; no clearing pass is needed. Write cfg only while idle.
`default_nettype none
module pure_pursuit_steering #(
    parameter int PATH_DEPTH = pps_pkg::PATH_DEPTH_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire pps_pkg::in_item_t        s_item,
    output logic                          m_valid,
    input  wire                           m_ready,
    output pps_pkg::out_item_t            m_item,
    input  wire                           cfg_we,
    input  wire                           cfg_addr,
    input  wire [pps_pkg::CFG_W-1:0]      cfg_wdata
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(PATH_DEPTH);
    localparam int CNT_W = $clog2(PATH_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_SQ, S_SUM, S_ROOT, S_LCMP,
        S_NEAR_RD, S_NEAR_WAIT, S_LOOK_RD, S_LOOK_WAIT,
        S_ROT_GO, S_ROT, S_CMD, S_OUT
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [IDX_W-1:0]           idx_reg, near_reg, look_reg;
    logic                       phase2_reg;
    logic signed [COORD_W-1:0]  car_x_reg, car_y_reg, ref_x_reg, ref_y_reg;
    logic signed [HEAD_W-1:0]   car_head_reg;
    logic signed [DIFF_W-1:0]   dx_reg, dy_reg;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg, best_reg;
    logic [ROOT_W:0]            bestd_reg;
    logic [LOOK_W-1:0]          look_dist_reg;
    logic [ANGLE_W-1:0]         angle_reg;
    logic                       m_valid_reg;
    out_item_t                  out_reg;

    logic                       accept, wr_en, rd_en, last;
    logic [IDX_W-1:0]           rd_addr;
    logic signed [COORD_W-1:0]  rd_x, rd_y, sel_x, sel_y;
    logic signed [SQ_W-1:0]     sqx_full, sqy_full;
    logic [SQ_W-1:0]            d2;
    logic                       root_done, rot_done, div_done;
    logic [ROOT_W-1:0]          root;
    logic signed [ROOT_W+1:0]   diff;
    logic [ROOT_W:0]            absd;
    logic signed [LAT_W-1:0]    lat;
    logic signed [CMD_W-1:0]    cmd;
    logic [IDX_W+INDEX_OUT_W-1:0] near_ext, look_ext;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (s_item.mode == MODE_APPEND)
                     && (count_reg < CNT_W'(PATH_DEPTH));
    assign rd_en   = (state_reg == S_RD) || (state_reg == S_NEAR_RD)
                     || (state_reg == S_LOOK_RD);
    assign rd_addr = (state_reg == S_RD) ? idx_reg :
                     (state_reg == S_NEAR_RD) ? near_reg : look_reg;
    assign last    = ({1'b0, idx_reg} == count_reg - CNT_W'(1));
    assign sel_x   = phase2_reg ? ref_x_reg : car_x_reg;
    assign sel_y   = phase2_reg ? ref_y_reg : car_y_reg;
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign d2      = sqx_reg + sqy_reg;
    assign diff    = $signed({2'b0, root}) - $signed({(ROOT_W+2-LOOK_W)'(0), look_dist_reg});
    assign absd    = diff[ROOT_W+1] ? (ROOT_W+1)'(-diff) : diff[ROOT_W:0];
    assign near_ext = {{INDEX_OUT_W{1'b0}}, near_reg};
    assign look_ext = {{INDEX_OUT_W{1'b0}}, look_reg};

    pps_point_mem #(.DEPTH(PATH_DEPTH)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_x    (s_item.coord_x),
        .wr_y    (s_item.coord_y),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    pps_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    ((state_reg == S_SUM) && phase2_reg),
        .radicand (d2),
        .done     (root_done),
        .root     (root)
    );

    pps_rotate u_rot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_ROT_GO),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .head    (car_head_reg),
        .done    (rot_done),
        .lat     (lat)
    );

    pps_cmd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   ((state_reg == S_ROT) && rot_done),
        .d       (lat),
        .look    (look_dist_reg),
        .angle   (angle_reg),
        .done    (div_done),
        .cmd     (cmd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            car_x_reg     <= '0;
            car_y_reg     <= '0;
            car_head_reg  <= '0;
            look_dist_reg <= LOOK_RESET;
            angle_reg     <= ANGLE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_LOOKAHEAD: look_dist_reg <= cfg_wdata[LOOK_W-1:0];
                    CFG_MAX_ANGLE: angle_reg <= cfg_wdata[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (wr_en) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (s_item.mode == MODE_POSE) begin
                            car_x_reg    <= s_item.coord_x;
                            car_y_reg    <= s_item.coord_y;
                            car_head_reg <= s_item.heading;
                        end
                        if (s_item.mode == MODE_TICK && count_reg != '0) begin
                            idx_reg    <= '0;
                            phase2_reg <= 1'b0;
                            state_reg  <= S_RD;
                        end
                    end
                end
                S_RD: state_reg <= S_WAIT;
                S_WAIT: begin
                    dx_reg    <= DIFF_W'(rd_x) - DIFF_W'(sel_x);
                    dy_reg    <= DIFF_W'(rd_y) - DIFF_W'(sel_y);
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    sqx_reg   <= $unsigned(sqx_full);
                    sqy_reg   <= $unsigned(sqy_full);
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    if (phase2_reg) begin
                        state_reg <= S_ROOT;
                    end else begin
                        if (idx_reg == '0 || d2 < best_reg) begin
                            best_reg <= d2;
                            near_reg <= idx_reg;
                        end
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= last ? S_NEAR_RD : S_RD;
                    end
                end
                S_ROOT: begin
                    if (root_done) begin
                        state_reg <= S_LCMP;
                    end
                end
                S_LCMP: begin
                    if (idx_reg == '0 || absd < bestd_reg) begin
                        bestd_reg <= absd;
                        look_reg  <= idx_reg;
                    end
                    idx_reg   <= idx_reg + IDX_W'(1);
                    state_reg <= last ? S_LOOK_RD : S_RD;
                end
                S_NEAR_RD: state_reg <= S_NEAR_WAIT;
                S_NEAR_WAIT: begin
                    ref_x_reg  <= rd_x;
                    ref_y_reg  <= rd_y;
                    idx_reg    <= '0;
                    phase2_reg <= 1'b1;
                    state_reg  <= S_RD;
                end
                S_LOOK_RD: state_reg <= S_LOOK_WAIT;
                S_LOOK_WAIT: begin
                    dx_reg    <= DIFF_W'(rd_x) - DIFF_W'(car_x_reg);
                    dy_reg    <= DIFF_W'(rd_y) - DIFF_W'(car_y_reg);
                    state_reg <= S_ROT_GO;
                end
                S_ROT_GO: state_reg <= S_ROT;
                S_ROT: begin
                    if (rot_done) begin
                        state_reg <= S_CMD;
                    end
                end
                S_CMD: begin
                    if (div_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.steering_command <= cmd;
                        out_reg.closest_index    <= near_ext[INDEX_OUT_W-1:0];
                        out_reg.lookahead_index  <= look_ext[INDEX_OUT_W-1:0];
                        m_valid_reg              <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_pure_pursuit_steering.sv =====
// Self-checking testbench for pure_pursuit_steering: random and directed path, pose and tick
// transfers, with a scoreboard that predicts the nearest and lookahead points and the command.
// Depends on pps_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb_pure_pursuit_steering;
    import pps_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_PATH_CAP = 40;

    class steer_tracker;
        int path_x[DEPTH];
        int path_y[DEPTH];
        int point_count;
        int car_x, car_y, car_heading;
        longint unsigned look_dist, max_angle;
        out_item_t pending_cmds[$];
        int mismatches;
        int results_seen;
        int items_taken;

        function new();
            point_count = 0;
            car_x = 0;
            car_y = 0;
            car_heading = 0;
            look_dist = 32768;
            max_angle = 4096;
            mismatches = 0;
            results_seen = 0;
            items_taken = 0;
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] val);
            if (idx == CFG_LOOKAHEAD) look_dist = val;
            else max_angle = val[ANGLE_W-1:0];
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint lateral_offset(longint dx, longint dy, int head);
            longint x, y, xs, ys, t;
            int z;
            x = dx * 256;
            y = dy * 256;
            z = -head;
            if (z > 16384) begin
                x = -x; y = -y; z = z - 32768;
            end else if (z < -16384) begin
                x = -x; y = -y; z = z + 32768;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - int'(atan_entry(i[3:0]));
                end else begin
                    x = x + ys; y = y - xs; z = z + int'(atan_entry(i[3:0]));
                end
            end
            t = (y >>> 8) * longint'(652032874) + (longint'(1) << 29);
            return t >>> 30;
        endfunction

        function longint steer_value(longint d);
            bit [63:0] mag, den, r, q;
            if (d == 0) return 0;
            mag = (d < 0) ? -d : d;
            den = look_dist * look_dist * max_angle;
            r = mag << 29;
            q = 0;
            if (r >= den) begin
                q = 16384;
            end else begin
                for (int i = 0; i < 14; i++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= den) begin
                        r = r - den;
                        q[0] = 1'b1;
                    end
                end
            end
            return (d < 0) ? -longint'(q) : longint'(q);
        endfunction

        function longint unsigned sq_dist(int ax, int ay, int bx, int by);
            longint dx, dy;
            dx = longint'(ax) - bx;
            dy = longint'(ay) - by;
            return longint'(dx * dx) + longint'(dy * dy);
        endfunction

        function void note_item(in_item_t it);
            int near, look;
            longint unsigned best, d2;
            longint diff, best_diff, cmd;
            out_item_t res;
            items_taken++;
            if (it.mode == MODE_APPEND) begin
                if (point_count < DEPTH) begin
                    path_x[point_count] = it.coord_x;
                    path_y[point_count] = it.coord_y;
                    point_count++;
                end
                return;
            end
            if (it.mode == MODE_POSE) begin
                car_x = it.coord_x;
                car_y = it.coord_y;
                car_heading = it.heading;
                return;
            end
            if (it.mode != MODE_TICK || point_count == 0) return;
            near = 0;
            best = sq_dist(path_x[0], path_y[0], car_x, car_y);
            for (int i = 1; i < point_count; i++) begin
                d2 = sq_dist(path_x[i], path_y[i], car_x, car_y);
                if (d2 < best) begin
                    best = d2;
                    near = i;
                end
            end
            look = 0;
            best_diff = -1;
            for (int i = 0; i < point_count; i++) begin
                d2 = sq_dist(path_x[i], path_y[i], path_x[near], path_y[near]);
                diff = longint'(root_floor(d2)) - longint'(look_dist);
                if (diff < 0) diff = -diff;
                if (best_diff < 0 || diff < best_diff) begin
                    best_diff = diff;
                    look = i;
                end
            end
            cmd = steer_value(lateral_offset(longint'(path_x[look]) - car_x,
                                             longint'(path_y[look]) - car_y, car_heading));
            res.steering_command = cmd[CMD_W-1:0];
            res.closest_index = near[INDEX_OUT_W-1:0];
            res.lookahead_index = look[INDEX_OUT_W-1:0];
            pending_cmds = {pending_cmds, res};
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_cmds.size() == 0) begin
                $error("unexpected result transfer %h", got);
                mismatches++;
                return;
            end
            want = pending_cmds.pop_front();
            results_seen++;
            if (got.steering_command !== want.steering_command) begin
                $error("steering_command: expected %0d, got %0d",
                       want.steering_command, got.steering_command);
                mismatches++;
            end
            if (got.closest_index !== want.closest_index) begin
                $error("closest_index: expected %0d, got %0d",
                       want.closest_index, got.closest_index);
                mismatches++;
            end
            if (got.lookahead_index !== want.lookahead_index) begin
                $error("lookahead_index: expected %0d, got %0d",
                       want.lookahead_index, got.lookahead_index);
                mismatches++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_item;
    logic m_valid;
    logic m_ready;
    out_item_t m_item;
    logic cfg_we;
    logic cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    int tx_gap;
    int rx_gap;
    steer_tracker tracker;

    pure_pursuit_steering #(.PATH_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= rx_gap);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_item);
    end

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < tx_gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(it);
    endtask

    // hold the sender until every expected transfer has arrived
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_cmds.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.set_register(idx, val);
        @(posedge aclk);
    endtask

    function automatic in_item_t make_item(logic [1:0] mode, int x, int y, int h);
        in_item_t it;
        it.mode = mode;
        it.coord_x = x[COORD_W-1:0];
        it.coord_y = y[COORD_W-1:0];
        it.heading = h[HEAD_W-1:0];
        return it;
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(99) < 80) return int'($urandom_range(524288)) - 262144;
        return int'($urandom);
    endfunction

    function automatic in_item_t random_item();
        int pick;
        logic [1:0] mode;
        pick = $urandom_range(99);
        if (pick < 38 && tracker.point_count < RANDOM_PATH_CAP) mode = MODE_APPEND;
        else if (pick < 55) mode = MODE_POSE;
        else if (pick < 93) mode = MODE_TICK;
        else mode = MODE_SPARE;
        return make_item(mode, rand_coord(), rand_coord(), int'($urandom));
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) send_item(random_item());
        drain();
    endtask

    initial begin
        tracker = new();
        tx_gap = 34;
        rx_gap = 34;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= CFG_LOOKAHEAD;
        cfg_wdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(make_item(MODE_TICK, 0, 0, 0));
        send_item(make_item(MODE_SPARE, -1, -1, -1));
        send_item(make_item(MODE_APPEND, 8388607, 8388607, 0));
        send_item(make_item(MODE_APPEND, -8388608, -8388608, 0));
        send_item(make_item(MODE_APPEND, 0, 0, 0));
        send_item(make_item(MODE_APPEND, 65536, 0, 0));
        send_item(make_item(MODE_APPEND, 0, 32768, 0));
        send_item(make_item(MODE_TICK, 0, 0, 0));
        send_item(make_item(MODE_POSE, 0, 0, -32768));
        send_item(make_item(MODE_TICK, 0, 0, 0));
        send_item(make_item(MODE_POSE, 8388607, 8388607, 32767));
        send_item(make_item(MODE_TICK, 0, 0, 0));
        send_item(make_item(MODE_POSE, -8388608, -8388608, 16384));
        send_item(make_item(MODE_TICK, 0, 0, 0));
        send_item(make_item(MODE_POSE, 1000, -1000, -16384));
        send_item(make_item(MODE_TICK, 0, 0, 0));
        send_item(make_item(MODE_POSE, -500, 200, 16385));
        send_item(make_item(MODE_TICK, 0, 0, 0));
        send_item(make_item(MODE_SPARE, 12345, -6789, 4321));
        send_item(make_item(MODE_TICK, 0, 0, 0));
        drain();

        write_reg(CFG_LOOKAHEAD, 23'd1);
        write_reg(CFG_MAX_ANGLE, 23'd65535);
        random_phase(20);
        write_reg(CFG_LOOKAHEAD, 23'd8388607);
        write_reg(CFG_MAX_ANGLE, 23'd1);
        random_phase(20);
        tx_gap = 0;
        rx_gap = 0;
        write_reg(CFG_LOOKAHEAD, 23'd131072);
        write_reg(CFG_MAX_ANGLE, 23'd8192);
        random_phase(25);
        tx_gap = 34;
        rx_gap = 34;
        write_reg(CFG_LOOKAHEAD, 23'd0);
        write_reg(CFG_MAX_ANGLE, 23'd0);
        random_phase(10);
        write_reg(CFG_LOOKAHEAD, 23'($urandom_range(1, 400000)));
        write_reg(CFG_MAX_ANGLE, 23'($urandom_range(1, 65535)));
        random_phase(20);

        // fill the store, then push a few more that must be dropped
        write_reg(CFG_LOOKAHEAD, 23'd32768);
        write_reg(CFG_MAX_ANGLE, 23'd4096);
        while (tracker.point_count < DEPTH)
            send_item(make_item(MODE_APPEND, rand_coord(), rand_coord(), 0));
        for (int i = 0; i < 4; i++)
            send_item(make_item(MODE_APPEND, 0, 0, 0));
        send_item(make_item(MODE_POSE, rand_coord(), rand_coord(), int'($urandom)));
        send_item(make_item(MODE_TICK, 0, 0, 0));
        drain();

        if (tracker.pending_cmds.size() != 0) begin
            $error("%0d expected results never arrived", tracker.pending_cmds.size());
            tracker.mismatches++;
        end
        $display("Covered %0d input transfers and %0d steering results over six register",
                 tracker.items_taken, tracker.results_seen);
        $display("settings, including zero registers and a full point store.");
        if (tracker.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/pps_pkg.sv
sv/pps_point_mem.sv
sv/pps_isqrt.sv
sv/pps_rotate.sv
sv/pps_cmd_div.sv
sv/pure_pursuit_steering.sv
tb/sv/tb_pure_pursuit_steering.sv
